[hw/rtl/nec_ir_frame_decoder_assert.svh]
// Assertion macros shared by the NEC IR frame decoder RTL.
// Depends on nothing; the including module supplies the clock and reset names.
`ifndef NEC_IR_FRAME_DECODER_ASSERT_SVH
`define NEC_IR_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NECIR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NECIR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/necir_pkg.sv]
// Types and constants shared by the NEC IR frame decoder modules.
// No dependencies.
`default_nettype none

package necir_pkg;

    // Request opcodes.
    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Register indexes, decoded from paddr[2].
    localparam logic REG_DEVICE_ADDRESS = 1'b0;
    localparam logic REG_REPEAT_ENABLE  = 1'b1;
    localparam int   PADDR_WIDTH        = 3;
    localparam int   PDATA_WIDTH        = 32;

    // Timing thresholds in 64 us units.
    localparam int         UNIT_SHIFT = 6;
    localparam int         LEN_WIDTH  = 8;
    localparam logic [7:0] LEN_SAT    = 8'hff;
    localparam logic [7:0] MARK_MIN   = 8'h06;
    localparam logic [7:0] MARK_END   = 8'h0c;
    localparam logic [7:0] ZERO_END   = 8'h10;
    localparam logic [7:0] ONE_END    = 8'h20;
    localparam logic [7:0] REP_MIN    = 8'h1e;
    localparam logic [7:0] REP_MAX    = 8'h22;

    // Code byte positions.
    localparam int         CODE_BYTES = 4;
    localparam logic [1:0] ADDR_BYTE  = 2'd0;
    localparam logic [1:0] NADDR_BYTE = 2'd1;
    localparam logic [1:0] CMD_BYTE   = 2'd2;
    localparam logic [1:0] NCMD_BYTE  = 2'd3;

    localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'h00;
    localparam logic       REPEAT_ENABLE_RESET  = 1'b1;

    typedef struct packed {
        logic [7:0] device_address;
        logic       repeat_enable;
    } t_cfg;

    typedef struct packed {
        logic [7:0] code;
        logic       frame_ok;
        logic       repeated;
    } t_result;

endpackage

`default_nettype wire

[hw/rtl/necir_regs.sv]
// APB configuration registers of the NEC IR frame decoder.
// Depends on necir_pkg.
`default_nettype none

module necir_regs (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [necir_pkg::PADDR_WIDTH-1:0]     paddr,
    input  wire logic [necir_pkg::PDATA_WIDTH-1:0]     pwdata,
    output logic      [necir_pkg::PDATA_WIDTH-1:0]     prdata,
    output logic                                       pready,
    output necir_pkg::t_cfg                            o_cfg
);
    import necir_pkg::*;

    t_cfg r_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address <= DEVICE_ADDRESS_RESET;
            r_cfg.repeat_enable  <= REPEAT_ENABLE_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_DEVICE_ADDRESS: r_cfg.device_address <= pwdata[7:0];
                REG_REPEAT_ENABLE:  r_cfg.repeat_enable  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_DEVICE_ADDRESS: prdata = PDATA_WIDTH'(r_cfg.device_address);
            REG_REPEAT_ENABLE:  prdata = PDATA_WIDTH'(r_cfg.repeat_enable);
            default:            prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[hw/rtl/necir_core.sv]
// Decoder state and per-request logic: edge timing, bit capture, frame check.
// Depends on necir_pkg.
`default_nettype none

module necir_core #(
    parameter int STAMP_WIDTH = 32
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire necir_pkg::t_cfg         i_cfg,
    input  wire logic                    i_item_valid,
    input  wire logic                    i_op,
    input  wire logic                    i_line_level,
    input  wire logic [STAMP_WIDTH-1:0]  i_stamp,
    output necir_pkg::t_result           o_result
);
    import necir_pkg::*;

    localparam int SAT_LSB = UNIT_SHIFT + LEN_WIDTH;

    logic [7:0]             r_code_bytes [CODE_BYTES];
    logic [7:0]             r_bit_index;
    logic                   r_prev_level;
    logic [STAMP_WIDTH-1:0] r_prev_stamp;
    logic [7:0]             r_prev_length;
    logic                   r_repeat_pending;
    logic [7:0]             r_held_command;

    logic [7:0]             n_code_bytes [CODE_BYTES];
    logic [7:0]             n_bit_index;
    logic                   n_prev_level;
    logic [STAMP_WIDTH-1:0] n_prev_stamp;
    logic [7:0]             n_prev_length;
    logic                   n_repeat_pending;
    logic [7:0]             n_held_command;

    logic [STAMP_WIDTH-1:0] span;
    logic [7:0]             len;
    logic                   mark_ok;
    logic [1:0]             byte_sel;
    logic [2:0]             bit_sel;
    logic                   frame_ok;
    logic                   serve_repeat;

    // Span modulo 2^STAMP_WIDTH, in 64 us units, saturated to 8 bits.
    assign span = i_stamp - r_prev_stamp;
    assign len  = (|span[STAMP_WIDTH-1:SAT_LSB]) ? LEN_SAT : span[SAT_LSB-1:UNIT_SHIFT];

    assign mark_ok  = (r_prev_length >= MARK_MIN) && (r_prev_length < MARK_END);
    // Bits past index 31 keep landing in the last byte.
    assign byte_sel = (|r_bit_index[7:5]) ? NCMD_BYTE : r_bit_index[4:3];
    assign bit_sel  = r_bit_index[2:0];

    assign frame_ok = (r_code_bytes[ADDR_BYTE] == i_cfg.device_address)
                   && (r_code_bytes[NADDR_BYTE] == ~i_cfg.device_address)
                   && (r_code_bytes[CMD_BYTE] == ~r_code_bytes[NCMD_BYTE]);
    assign serve_repeat = r_repeat_pending && i_cfg.repeat_enable;

    always_comb begin
        n_code_bytes     = r_code_bytes;
        n_bit_index      = r_bit_index;
        n_prev_level     = r_prev_level;
        n_prev_stamp     = r_prev_stamp;
        n_prev_length    = r_prev_length;
        n_repeat_pending = r_repeat_pending;
        n_held_command   = r_held_command;
        if (i_item_valid) begin
            if (i_op == OP_EDGE) begin
                if (r_prev_level) begin
                    if (mark_ok) begin
                        // A space past the one-bit limit leaves the bit alone.
                        if (len < ZERO_END) begin
                            n_code_bytes[byte_sel][bit_sel] = 1'b0;
                        end else if (len < ONE_END) begin
                            n_code_bytes[byte_sel][bit_sel] = 1'b1;
                        end
                        n_bit_index = r_bit_index + 8'd1;
                    end else begin
                        n_bit_index      = '0;
                        n_repeat_pending = (len >= REP_MIN) && (len <= REP_MAX);
                    end
                end
                n_prev_level  = i_line_level;
                n_prev_stamp  = i_stamp;
                n_prev_length = len;
            end else begin
                if (frame_ok) begin
                    n_held_command = r_code_bytes[CMD_BYTE];
                end
                if (serve_repeat) begin
                    n_repeat_pending = 1'b0;
                end
            end
        end
    end

    always_comb begin
        o_result.frame_ok = frame_ok;
        o_result.repeated = serve_repeat;
        if (serve_repeat) begin
            o_result.code = n_held_command;
        end else if (frame_ok) begin
            o_result.code = r_code_bytes[CMD_BYTE];
        end else begin
            o_result.code = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CODE_BYTES; i++) begin
                r_code_bytes[i] <= '0;
            end
            r_bit_index      <= '0;
            r_prev_level     <= 1'b1;
            r_prev_stamp     <= '0;
            r_prev_length    <= '0;
            r_repeat_pending <= 1'b0;
            r_held_command   <= '0;
        end else begin
            r_code_bytes     <= n_code_bytes;
            r_bit_index      <= n_bit_index;
            r_prev_level     <= n_prev_level;
            r_prev_stamp     <= n_prev_stamp;
            r_prev_length    <= n_prev_length;
            r_repeat_pending <= n_repeat_pending;
            r_held_command   <= n_held_command;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/nec_ir_frame_decoder.sv]
// NEC IR frame decoder. An accepted read request waits in the input stage until the
// result register is free, then its result moves into it and drives o_out_valid.
// Throughput: one request per cycle while no read waits in the input stage; edge
// requests produce no result and never wait on the output side. Reset: synchronous,
// active low; clears decoder state, device_address to 0 and repeat_enable to 1.
// Depends on necir_pkg, necir_regs, necir_core and the assert header.
`default_nettype none
`include "nec_ir_frame_decoder_assert.svh"

module nec_ir_frame_decoder #(
    parameter int STAMP_WIDTH = 32
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [necir_pkg::PADDR_WIDTH-1:0]     paddr,
    input  wire logic [necir_pkg::PDATA_WIDTH-1:0]     pwdata,
    output logic      [necir_pkg::PDATA_WIDTH-1:0]     prdata,
    output logic                                       pready,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic                                  i_op,
    input  wire logic                                  i_line_level,
    input  wire logic [STAMP_WIDTH-1:0]                i_stamp_us,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic [7:0]                                 o_code,
    output logic                                       o_frame_ok,
    output logic                                       o_repeated
);
    import necir_pkg::*;

    t_cfg                   cfg;
    t_result                core_result;

    logic                   r_s1_valid;
    logic                   r_s1_op;
    logic                   r_s1_level;
    logic [STAMP_WIDTH-1:0] r_s1_stamp;
    logic                   r_out_valid;
    t_result                r_out;

    logic                   out_free;
    logic                   s1_advance;
    logic                   res_load;
    logic                   in_take;

    necir_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Edge requests retire without touching the result register.
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_advance = r_s1_valid && ((r_s1_op == OP_EDGE) || out_free);
    assign res_load   = s1_advance && (r_s1_op == OP_READ);
    assign o_in_ready = !r_s1_valid || s1_advance;
    assign in_take    = i_in_valid && o_in_ready;

    necir_core #(
        .STAMP_WIDTH (STAMP_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item_valid (s1_advance),
        .i_op         (r_s1_op),
        .i_line_level (r_s1_level),
        .i_stamp      (r_s1_stamp),
        .o_result     (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_op    <= i_op;
            r_s1_level <= i_line_level;
            r_s1_stamp <= i_stamp_us;
        end
        if (res_load) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_code      = r_out.code;
    assign o_frame_ok  = r_out.frame_ok;
    assign o_repeated  = r_out.repeated;

    `NECIR_ASSERT_IMP(a_load_only_when_free, i_clk, i_rst_n, res_load, out_free,
        "result register overwritten while still held")
    `NECIR_ASSERT_IMP(a_load_only_reads, i_clk, i_rst_n, res_load, r_s1_op == OP_READ,
        "result produced by an edge request")
    `NECIR_ASSERT_IMP(a_repeat_needs_enable, i_clk, i_rst_n, r_out_valid && r_out.repeated,
        cfg.repeat_enable, "repeat served while repeat is disabled")
    `NECIR_ASSERT_NEXT(a_take_fills_stage, i_clk, i_rst_n, in_take, r_s1_valid,
        "accepted request lost from the input stage")

endmodule

`default_nettype wire
